@@ hdl/content_bounding_box_crop_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the content bounding box crop core.
// ---------------------------------------------------------------------------
`ifndef CONTENT_BOUNDING_BOX_CROP_CORE_ASSERT_SVH
`define CONTENT_BOUNDING_BOX_CROP_CORE_ASSERT_SVH

// The asserting module names its clock clock and its reset reset.

// Checked at every rising edge outside of reset.
`define CCROP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CCROP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/ccrop_pkg.sv @@
// ---------------------------------------------------------------------------
// ccrop_pkg
// Shared constants, types and helpers of the content bounding box crop core.
// ---------------------------------------------------------------------------
`default_nettype none

package ccrop_pkg;

   // Largest frame dimension supported, in pixels.
   localparam int MAX_DIM   = 4096;
   // Width of a column or row position.
   localparam int POS_W     = $clog2(MAX_DIM);
   // Width of a size that can hold MAX_DIM itself.
   localparam int DIM_W     = POS_W + 1;
   // Width of the size registers as written through the register port.
   localparam int REG_DIM_W = 13;
   localparam int PIXEL_W   = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BACKGROUND_COLOR = 2'd0,
      CSR_FRAME_WIDTH      = 2'd1,
      CSR_FRAME_HEIGHT     = 2'd2
   } ccrop_csr_index_type;

   // Working configuration, with the frame size already clamped.
   typedef struct packed {
      logic [PIXEL_W-1:0] background_color;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
   } ccrop_cfg_type;

   // Extent of the foreground of one finished frame.
   typedef struct packed {
      logic [POS_W-1:0] min_column;
      logic [POS_W-1:0] max_column;
      logic [POS_W-1:0] min_row;
      logic [POS_W-1:0] max_row;
      logic             found_any;
   } ccrop_extent_type;

   // A size of zero counts as one, and anything above MAX_DIM as MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ccrop_if.sv @@
// ---------------------------------------------------------------------------
// ccrop_req_if / ccrop_rsp_if
// Valid/ready channels for pixels in and crop boxes out.
// ---------------------------------------------------------------------------
`default_nettype none

interface ccrop_req_if;
   logic                          valid;
   logic                          ready;
   logic [ccrop_pkg::PIXEL_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ccrop_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ccrop_pkg::POS_W-1:0] box_left;
   logic [ccrop_pkg::POS_W-1:0] box_top;
   logic [ccrop_pkg::DIM_W-1:0] box_width;
   logic [ccrop_pkg::DIM_W-1:0] box_height;
   logic                        frame_empty;

   modport source (output valid, output box_left, output box_top, output box_width,
                   output box_height, output frame_empty, input ready);
   modport sink   (input valid, input box_left, input box_top, input box_width,
                   input box_height, input frame_empty, output ready);
endinterface

`default_nettype wire

@@ hdl/ccrop_csr.sv @@
// ---------------------------------------------------------------------------
// ccrop_csr
// Configuration registers; presents the background color and clamped size.
// ---------------------------------------------------------------------------
`default_nettype none

module ccrop_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [ccrop_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ccrop_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output ccrop_pkg::ccrop_cfg_type               cfg
);

   logic [ccrop_pkg::PIXEL_W-1:0]   background_ff, background_in;
   logic [ccrop_pkg::REG_DIM_W-1:0] width_ff, width_in;
   logic [ccrop_pkg::REG_DIM_W-1:0] height_ff, height_in;

   always_comb begin
      background_in = background_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            ccrop_pkg::CSR_BACKGROUND_COLOR: begin
               background_in = csr_write_data[ccrop_pkg::PIXEL_W-1:0];
            end
            ccrop_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_write_data[ccrop_pkg::REG_DIM_W-1:0];
            end
            ccrop_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_write_data[ccrop_pkg::REG_DIM_W-1:0];
            end
            default: begin
               // Unused index: the write is dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         background_ff <= '0;
         width_ff      <= ccrop_pkg::REG_DIM_W'(ccrop_pkg::MAX_DIM);
         height_ff     <= ccrop_pkg::REG_DIM_W'(ccrop_pkg::MAX_DIM);
      end else begin
         background_ff <= background_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
      end
   end

   assign cfg.background_color = background_ff;
   assign cfg.width            = ccrop_pkg::clamp_dim(width_ff);
   assign cfg.height           = ccrop_pkg::clamp_dim(height_ff);

endmodule

`default_nettype wire

@@ hdl/ccrop_tracker.sv @@
// ---------------------------------------------------------------------------
// ccrop_tracker
// Input register, raster position counters and foreground extent tracking.
// ---------------------------------------------------------------------------
`default_nettype none

module ccrop_tracker (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ccrop_pkg::ccrop_cfg_type cfg,
   ccrop_req_if.sink                    req,
   output logic                         ext_valid,
   input  wire logic                    ext_ready,
   output ccrop_pkg::ccrop_extent_type  ext
);

   localparam int PW = ccrop_pkg::POS_W;
   localparam int DW = ccrop_pkg::DIM_W;

   logic                          pix_valid_ff, pix_valid_in;
   logic [ccrop_pkg::PIXEL_W-1:0] pix_ff;
   logic [PW-1:0]                 column_ff, column_in;
   logic [PW-1:0]                 row_ff, row_in;
   ccrop_pkg::ccrop_extent_type   track_ff, track_in, track_hit;

   logic hit;
   logic row_end;
   logic frame_end;
   logic advance;

   assign hit       = (pix_ff != cfg.background_color);
   assign row_end   = ((DW'(column_ff) + DW'(1)) >= cfg.width);
   assign frame_end = row_end && ((DW'(row_ff) + DW'(1)) >= cfg.height);

   // A frame-closing pixel waits until the box stage can take its extent.
   assign advance   = pix_valid_ff && (!frame_end || ext_ready);
   assign req.ready = !pix_valid_ff || advance;

   assign ext_valid = pix_valid_ff && frame_end;
   assign ext       = track_hit;

   // Extent including the pixel in the input register.
   always_comb begin
      track_hit = track_ff;
      if (hit) begin
         track_hit.found_any = 1'b1;
         if (!track_ff.found_any) begin
            track_hit.min_column = column_ff;
            track_hit.max_column = column_ff;
            track_hit.min_row    = row_ff;
            track_hit.max_row    = row_ff;
         end else begin
            if (column_ff < track_ff.min_column) track_hit.min_column = column_ff;
            if (column_ff > track_ff.max_column) track_hit.max_column = column_ff;
            if (row_ff < track_ff.min_row)       track_hit.min_row    = row_ff;
            if (row_ff > track_ff.max_row)       track_hit.max_row    = row_ff;
         end
      end
   end

   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      track_in     = track_ff;
      pix_valid_in = pix_valid_ff;
      if (advance) begin
         pix_valid_in = 1'b0;
         if (frame_end) begin
            column_in = '0;
            row_in    = '0;
            track_in  = '0;
         end else if (row_end) begin
            column_in = '0;
            row_in    = row_ff + PW'(1);
            track_in  = track_hit;
         end else begin
            column_in = column_ff + PW'(1);
            track_in  = track_hit;
         end
      end
      if (req.valid && req.ready) begin
         pix_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         track_ff     <= '0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         track_ff     <= track_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         pix_ff <= req.pixel_value;
      end
   end

endmodule

`default_nettype wire

@@ hdl/ccrop_box.sv @@
// ---------------------------------------------------------------------------
// ccrop_box
// Holds a finished frame's extent and turns it into the registered crop box.
// ---------------------------------------------------------------------------
`default_nettype none

module ccrop_box (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        ext_valid,
   output logic                             ext_ready,
   input  wire ccrop_pkg::ccrop_extent_type ext,
   ccrop_rsp_if.source                      rsp
);

   localparam int PW = ccrop_pkg::POS_W;
   localparam int DW = ccrop_pkg::DIM_W;

   logic                        fin_valid_ff, fin_valid_in;
   ccrop_pkg::ccrop_extent_type fin_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [PW-1:0]               left_ff, top_ff;
   logic [DW-1:0]               width_ff, height_ff;
   logic                        empty_ff;

   logic          fin_move;
   logic [PW-1:0] left, top;
   logic [DW-1:0] right, bottom;

   assign fin_move  = fin_valid_ff && (!out_valid_ff || rsp.ready);
   assign ext_ready = !fin_valid_ff || fin_move;

   // One pixel of margin on the left and top where there is room.
   assign left   = (fin_ff.min_column == '0) ? '0 : fin_ff.min_column - PW'(1);
   assign top    = (fin_ff.min_row == '0) ? '0 : fin_ff.min_row - PW'(1);
   assign right  = DW'(fin_ff.max_column) + DW'(1);
   assign bottom = DW'(fin_ff.max_row) + DW'(1);

   always_comb begin
      fin_valid_in = fin_valid_ff;
      out_valid_in = out_valid_ff;
      if (fin_move) begin
         fin_valid_in = 1'b0;
      end
      if (ext_valid && ext_ready) begin
         fin_valid_in = 1'b1;
      end
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (fin_move) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ext_valid && ext_ready) begin
         fin_ff <= ext;
      end
      if (fin_move) begin
         if (fin_ff.found_any) begin
            left_ff   <= left;
            top_ff    <= top;
            width_ff  <= right - DW'(left);
            height_ff <= bottom - DW'(top);
            empty_ff  <= 1'b0;
         end else begin
            left_ff   <= '0;
            top_ff    <= '0;
            width_ff  <= '0;
            height_ff <= '0;
            empty_ff  <= 1'b1;
         end
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.box_left    = left_ff;
   assign rsp.box_top     = top_ff;
   assign rsp.box_width   = width_ff;
   assign rsp.box_height  = height_ff;
   assign rsp.frame_empty = empty_ff;

endmodule

`default_nettype wire

@@ hdl/content_bounding_box_crop_core.sv @@
// ---------------------------------------------------------------------------
// content_bounding_box_crop_core
// Finds the crop box around all non-background pixels of a raster frame.
// ---------------------------------------------------------------------------
// Pixels enter on req_chan, one 32-bit item per pixel in row-major order, and
// one crop box leaves on rsp_chan after the last pixel of each frame, as set
// by the frame width and height registers (0 counts as 1, sizes above 4096
// count as 4096). The csr_ port writes the background color and frame size;
// write it only while no frame is in progress.
// A pixel may be accepted in every clock cycle while req_chan.ready is high.
// The box for a frame is valid on rsp_chan once its last pixel has passed the
// input register, where the position counters and extent are updated, and
// the hold register, from which the box arithmetic loads the output
// register. The hold and output registers together buffer two boxes, so a
// stalled receiver does not stop the pixel stream; only a frame-closing pixel
// with both of them full waits in the input register, and req_chan.ready then
// drops. Results are never dropped or repeated.
// Reset (synchronous, active high) empties the pipeline, sets the position to
// the first pixel of a frame, clears the extent, sets the background color to
// zero and both frame dimensions to 4096.
// ---------------------------------------------------------------------------
`default_nettype none

module content_bounding_box_crop_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ccrop_req_if.sink                              req_chan,
   ccrop_rsp_if.source                            rsp_chan,
   input  wire logic                              csr_write_en,
   input  wire logic [ccrop_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ccrop_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // Working configuration, sizes already clamped to the legal range.
   ccrop_pkg::ccrop_cfg_type    cfg;
   // Extent of a finished frame on its way to the box stage.
   ccrop_pkg::ccrop_extent_type ext;
   logic                        ext_valid;
   logic                        ext_ready;

   ccrop_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // Counts the raster position and grows the extent pixel by pixel.
   ccrop_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_chan),
      .ext_valid (ext_valid),
      .ext_ready (ext_ready),
      .ext       (ext)
   );

   // Applies the margin and forms width and height of the finished box.
   ccrop_box u_box (
      .clock     (clock),
      .reset     (reset),
      .ext_valid (ext_valid),
      .ext_ready (ext_ready),
      .ext       (ext),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

@@ hdl/ccrop_checker.sv @@
// ---------------------------------------------------------------------------
// ccrop_checker
// Port-level checks of the crop core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "content_bounding_box_crop_core_assert.svh"

module ccrop_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ccrop_pkg::POS_W-1:0] box_left,
   input wire logic [ccrop_pkg::POS_W-1:0] box_top,
   input wire logic [ccrop_pkg::DIM_W-1:0] box_width,
   input wire logic [ccrop_pkg::DIM_W-1:0] box_height,
   input wire logic                        frame_empty
);

   localparam int SUM_W = ccrop_pkg::DIM_W + 1;

   logic [SUM_W-1:0] right_edge;
   logic [SUM_W-1:0] bottom_edge;
   logic             rsp_stalled;
   logic             shown_empty;
   logic             shown_box;
   logic             box_is_zero;
   logic             size_nonzero;
   logic             box_fits;

   assign right_edge   = SUM_W'(box_left) + SUM_W'(box_width);
   assign bottom_edge  = SUM_W'(box_top) + SUM_W'(box_height);
   assign rsp_stalled  = rsp_valid && !rsp_ready;
   assign shown_empty  = rsp_valid && frame_empty;
   assign shown_box    = rsp_valid && !frame_empty;
   assign box_is_zero  = (box_left == '0) && (box_top == '0) &&
                         (box_width == '0) && (box_height == '0);
   assign size_nonzero = (box_width != '0) && (box_height != '0);
   assign box_fits     = (right_edge <= SUM_W'(ccrop_pkg::MAX_DIM)) &&
                         (bottom_edge <= SUM_W'(ccrop_pkg::MAX_DIM));

   `CCROP_ASSERT(a_rsp_held, rsp_stalled |=> rsp_valid, "box dropped while stalled")
   `CCROP_ASSERT(a_empty_zero, shown_empty |-> box_is_zero, "empty frame with nonzero box")
   `CCROP_ASSERT(a_box_nonzero, shown_box |-> size_nonzero, "foreground box of zero size")
   `CCROP_ASSERT(a_box_inside, rsp_valid |-> box_fits, "box reaches past the largest frame")
   `CCROP_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "box valid right after reset")

endmodule

bind content_bounding_box_crop_core ccrop_checker u_ccrop_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .box_left    (rsp_chan.box_left),
   .box_top     (rsp_chan.box_top),
   .box_width   (rsp_chan.box_width),
   .box_height  (rsp_chan.box_height),
   .frame_empty (rsp_chan.frame_empty)
);

`default_nettype wire

@@ tb/crop_box_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crop_box_checker
// Watches the pixel, box and register ports of the crop core, predicts the
// crop box of every frame and compares it with the box the core delivers.
// ---------------------------------------------------------------------------

module crop_box_checker
   import ccrop_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ccrop_req_if                   req_mon,
   ccrop_rsp_if                   rsp_mon,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     error_count,
   output int                     boxes_pending
);

   typedef struct packed {
      logic [POS_W-1:0] left;
      logic [POS_W-1:0] top;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             frame_empty;
   } crop_box_type;

   crop_box_type expected_boxes[$];
   crop_box_type want_box;
   crop_box_type seen_box;
   int           mismatches;

   // Shadow copy of the registers and of the frame scan position.
   logic [PIXEL_W-1:0]   background;
   logic [REG_DIM_W-1:0] width_reg;
   logic [REG_DIM_W-1:0] height_reg;
   int                   scan_col;
   int                   scan_row;
   int                   hit_col_lo;
   int                   hit_col_hi;
   int                   hit_row_lo;
   int                   hit_row_hi;
   logic                 hit_seen;

   function automatic int size_in_force(input logic [REG_DIM_W-1:0] raw);
      if (raw == '0) return 1;
      if (int'(raw) > MAX_DIM) return MAX_DIM;
      return int'(raw);
   endfunction

   task automatic restart_frame();
      scan_col   = 0;
      scan_row   = 0;
      hit_col_lo = 0;
      hit_col_hi = 0;
      hit_row_lo = 0;
      hit_row_hi = 0;
      hit_seen   = 1'b0;
   endtask

   // Folds one pixel into the extent and queues the box when it closes a frame.
   task automatic absorb_pixel(input logic [PIXEL_W-1:0] pix);
      int           cols;
      int           rows;
      int           left;
      int           top;
      crop_box_type box;
      cols = size_in_force(width_reg);
      rows = size_in_force(height_reg);
      if (pix != background) begin
         if (!hit_seen) begin
            hit_col_lo = scan_col;
            hit_col_hi = scan_col;
            hit_row_lo = scan_row;
            hit_row_hi = scan_row;
            hit_seen   = 1'b1;
         end else begin
            if (scan_col < hit_col_lo) hit_col_lo = scan_col;
            if (scan_col > hit_col_hi) hit_col_hi = scan_col;
            if (scan_row < hit_row_lo) hit_row_lo = scan_row;
            if (scan_row > hit_row_hi) hit_row_hi = scan_row;
         end
      end
      if (scan_col + 1 < cols) begin
         scan_col = scan_col + 1;
      end else if (scan_row + 1 < rows) begin
         scan_col = 0;
         scan_row = scan_row + 1;
      end else begin
         box = '0;
         if (hit_seen) begin
            left       = (hit_col_lo > 0) ? hit_col_lo - 1 : 0;
            top        = (hit_row_lo > 0) ? hit_row_lo - 1 : 0;
            box.left   = POS_W'(left);
            box.top    = POS_W'(top);
            box.width  = DIM_W'(hit_col_hi + 1 - left);
            box.height = DIM_W'(hit_row_hi + 1 - top);
         end else begin
            box.frame_empty = 1'b1;
         end
         expected_boxes.push_back(box);
         restart_frame();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         background = '0;
         width_reg  = REG_DIM_W'(MAX_DIM);
         height_reg = REG_DIM_W'(MAX_DIM);
         restart_frame();
         expected_boxes.delete();
         mismatches = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_BACKGROUND_COLOR: background = csr_write_data[PIXEL_W-1:0];
               CSR_FRAME_WIDTH:      width_reg  = csr_write_data[REG_DIM_W-1:0];
               CSR_FRAME_HEIGHT:     height_reg = csr_write_data[REG_DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_pixel(req_mon.pixel_value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_box = '{rsp_mon.box_left, rsp_mon.box_top, rsp_mon.box_width,
                         rsp_mon.box_height, rsp_mon.frame_empty};
            if (expected_boxes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected box l=%0d t=%0d w=%0d h=%0d e=%0b",
                        $time, seen_box.left, seen_box.top, seen_box.width,
                        seen_box.height, seen_box.frame_empty);
            end else begin
               want_box = expected_boxes.pop_front();
               if (seen_box !== want_box) begin
                  mismatches++;
                  $display("%0t: expected l=%0d t=%0d w=%0d h=%0d e=%0b",
                           $time, want_box.left, want_box.top, want_box.width,
                           want_box.height, want_box.frame_empty);
                  $display("%0t: actual   l=%0d t=%0d w=%0d h=%0d e=%0b",
                           $time, seen_box.left, seen_box.top, seen_box.width,
                           seen_box.height, seen_box.frame_empty);
               end
            end
         end
      end
      error_count   <= mismatches;
      boxes_pending <= expected_boxes.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the content bounding box crop core: directed
// frames, a long run of small random frames and frames sized past the limit.
// ---------------------------------------------------------------------------

module tb;
   import ccrop_pkg::*;

   localparam int RESULT_LATENCY = 2;
   localparam int SETTLE_CYCLES  = 2 * RESULT_LATENCY + 2;
   localparam int RANDOM_ITEMS   = 800;
   localparam int CYCLE_LIMIT    = 400000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     error_count;
   int                     boxes_pending;

   // 0: sender idles 35 percent, receiver 48; 1: the other way round; 2: no idling.
   int                     idle_mode;
   int                     items_sent;
   int                     cycle_count = 0;

   // Register values last written, so frames can be sized and painted.
   logic [PIXEL_W-1:0]     cur_bg;
   logic [REG_DIM_W-1:0]   cur_w;
   logic [REG_DIM_W-1:0]   cur_h;

   ccrop_req_if req_if ();
   ccrop_rsp_if rsp_if ();

   content_bounding_box_crop_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   crop_box_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .error_count    (error_count),
      .boxes_pending  (boxes_pending)
   );

   always #5 clock = ~clock;

   // The cycle counter is the only timeout: a lost box shows up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d boxes still outstanding", $time, boxes_pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver stalls at random according to the current idle mode.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         case (idle_mode)
            0:       rsp_if.ready <= ($urandom_range(99) >= 48);
            1:       rsp_if.ready <= ($urandom_range(99) >= 35);
            default: rsp_if.ready <= 1'b1;
         endcase
      end
   end

   function automatic int sender_idle_percent();
      case (idle_mode)
         0:       return 35;
         1:       return 48;
         default: return 0;
      endcase
   endfunction

   // Number of pixels in one frame at the given raw register values.
   function automatic int pixels_per_frame(input logic [REG_DIM_W-1:0] w,
                                           input logic [REG_DIM_W-1:0] h);
      int cols;
      int rows;
      cols = (w == '0) ? 1 : ((int'(w) > MAX_DIM) ? MAX_DIM : int'(w));
      rows = (h == '0) ? 1 : ((int'(h) > MAX_DIM) ? MAX_DIM : int'(h));
      return cols * rows;
   endfunction

   // A pixel meant to stand out; it may still happen to match the background.
   function automatic logic [PIXEL_W-1:0] foreground_pixel();
      case ($urandom_range(3))
         0:       return ~cur_bg;
         1:       return $urandom();
         2:       return {PIXEL_W{1'b1}};
         default: return '0;
      endcase
   endfunction

   // Offers one item, with random idle cycles in front, and returns at the
   // edge where the core takes it. valid is left high for a following item.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      while ($urandom_range(99) < sender_idle_percent()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.pixel_value <= pix;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // Holds the sender back until every box has arrived and the last pixel
   // has surely left the core's input register.
   task automatic drain();
      req_if.valid <= 1'b0;
      repeat (RESULT_LATENCY) @(posedge clock);
      while (boxes_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges; the core must be idle.
   task automatic apply_settings(input logic [PIXEL_W-1:0]   bg,
                                 input logic [REG_DIM_W-1:0] w,
                                 input logic [REG_DIM_W-1:0] h);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_BACKGROUND_COLOR;
      csr_write_data <= bg;
      @(posedge clock);
      csr_index      <= CSR_FRAME_WIDTH;
      csr_write_data <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index      <= CSR_FRAME_HEIGHT;
      csr_write_data <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cur_bg = bg;
      cur_w  = w;
      cur_h  = h;
   endtask

   // Sends a run of pixels: each stands out with the given chance, and the
   // first and last can be forced to stand out to pin the box edges.
   task automatic send_frame(input int count, input int hit_percent,
                             input bit first_hit, input bit last_hit);
      logic [PIXEL_W-1:0] pix;
      for (int i = 0; i < count; i++) begin
         if ((first_hit && i == 0) || (last_hit && i == count - 1) ||
             ($urandom_range(99) < hit_percent)) begin
            pix = foreground_pixel();
         end else begin
            pix = cur_bg;
         end
         send_pixel(pix);
      end
   endtask

   initial begin
      logic [PIXEL_W-1:0]   bg;
      logic [REG_DIM_W-1:0] w;
      logic [REG_DIM_W-1:0] h;
      int                   frame_len;
      int                   first_part;
      int                   hit_percent;
      int                   random_base;

      req_if.valid       = 1'b0;
      req_if.pixel_value = '0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_BACKGROUND_COLOR;
      csr_write_data     = '0;
      reset              = 1'b1;
      idle_mode          = 0;
      items_sent         = 0;
      cur_bg             = '0;
      cur_w              = REG_DIM_W'(MAX_DIM);
      cur_h              = REG_DIM_W'(MAX_DIM);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames. A 3x2 frame that is all background gives the empty
      // box, then the same frame with one hit in the lower right corner.
      apply_settings('0, 3, 2);
      send_frame(6, 0, 0, 0);
      repeat (5) send_pixel('0);
      send_pixel({PIXEL_W{1'b1}});
      drain();

      // Zero sizes count as one, so every pixel is a frame of its own.
      apply_settings('0, 0, 0);
      send_pixel({PIXEL_W{1'b1}});
      send_pixel('0);
      drain();

      // An all-ones background turns the polarity of the previous pair round.
      apply_settings({PIXEL_W{1'b1}}, 1, 1);
      send_pixel({PIXEL_W{1'b1}});
      send_pixel('0);
      drain();

      // The size changes in the middle of a frame. Shrinking the width to 2
      // while the scan sits at column 2 ends the row at once; shrinking the
      // height to 1 while on row 1 ends the frame at the end of that row.
      apply_settings('0, 4, 2);
      send_pixel('0);
      send_pixel(32'h5a5a_5a5a);
      drain();
      apply_settings('0, 2, 2);
      send_pixel('0);
      drain();
      apply_settings('0, 2, 1);
      send_pixel('0);
      send_pixel('0);
      drain();

      // Random small frames. The idle mode steps through its three settings
      // as the run goes on; frames mostly line up with the programmed size.
      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         if (items_sent - random_base < RANDOM_ITEMS / 3) begin
            idle_mode <= 0;
         end else if (items_sent - random_base < 2 * RANDOM_ITEMS / 3) begin
            idle_mode <= 1;
         end else begin
            idle_mode <= 2;
         end
         if ($urandom_range(99) < 40) begin
            drain();
            case ($urandom_range(3))
               0:       bg = '0;
               1:       bg = {PIXEL_W{1'b1}};
               default: bg = $urandom();
            endcase
            w = ($urandom_range(9) == 0) ? '0 : REG_DIM_W'($urandom_range(1, 8));
            h = ($urandom_range(9) == 0) ? '0 : REG_DIM_W'($urandom_range(1, 8));
            apply_settings(bg, w, h);
         end
         case ($urandom_range(3))
            0:       hit_percent = 0;
            1:       hit_percent = 15;
            2:       hit_percent = 50;
            default: hit_percent = 90;
         endcase
         frame_len = pixels_per_frame(cur_w, cur_h);
         if (frame_len > 1 && $urandom_range(99) < 8) begin
            // Resize part way through; the scan keeps its position.
            first_part = $urandom_range(1, frame_len - 1);
            send_frame(first_part, hit_percent, 0, 0);
            drain();
            apply_settings(cur_bg, REG_DIM_W'($urandom_range(0, 8)),
                           REG_DIM_W'($urandom_range(0, 8)));
            frame_len = pixels_per_frame(cur_w, cur_h);
         end
         send_frame(frame_len, hit_percent, $urandom_range(3) == 0, $urandom_range(3) == 0);
      end

      // Sizes above the largest frame count as the largest one, so a short
      // run of pixels does not close the frame; a small size then does. The
      // scan may sit part way into a frame after a resize, so the core is
      // brought back to the start of a frame by a 1x1 setting first.
      idle_mode <= 2;
      drain();
      apply_settings(cur_bg, 1, 1);
      send_pixel(cur_bg);
      drain();
      apply_settings(~cur_bg, REG_DIM_W'($urandom_range(MAX_DIM + 1, 8191)), 1);
      send_frame(5, 50, 1, 1);
      drain();
      apply_settings(cur_bg, 3, 1);
      send_pixel(~cur_bg);
      drain();
      apply_settings($urandom(), 1, REG_DIM_W'($urandom_range(MAX_DIM + 1, 8191)));
      send_frame(3, 0, 0, 1);
      drain();
      apply_settings(cur_bg, 1, 2);
      send_pixel(cur_bg);

      drain();
      if (error_count == 0 && boxes_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
